// ===== rtl/psa_pkg.sv =====
// psa_pkg: shared types, codes and defaults of the paged stack allocator
// used by every module in rtl; depends on nothing else
package psa_pkg;

	// default sizing, handed down to the top level parameters
	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 24;
	localparam int STACK_DEPTH_DEF  = 256;

	// fixed field widths
	localparam int LEN_W   = 12;
	localparam int ADDR_W  = 32;
	localparam int PAGES_W = 13;
	localparam int NEED_W  = 13;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_LEN  = 3'd1;
	localparam logic [2:0] ST_NO_PAGES = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// register indexes and reset values
	localparam logic [1:0] REG_MAX_ALLOC  = 2'd0;
	localparam logic [1:0] REG_HEAP_START = 2'd1;
	localparam logic [1:0] REG_MAX_PAGES  = 2'd2;

	localparam logic [LEN_W-1:0]   MAX_ALLOC_RST  = 12'd512;
	localparam logic [ADDR_W-1:0]  HEAP_START_RST = 32'd0;
	localparam logic [PAGES_W-1:0] MAX_PAGES_RST  = 13'd16;

	typedef struct packed {
		logic             cmd;
		logic [LEN_W-1:0] req_len;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] buf_address;
		logic [LEN_W-1:0]  freed_len;
	} out_item_t;

	// shift control for the row of stack cells
	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

endpackage

// ===== rtl/paged_stack_allocator_top.sv =====
// paged_stack_allocator_top: paged lifo buffer allocator with apb register port
// depends on psa_pkg and psa_stack (which builds on psa_cell)
//
// The allocator hands out buffers last-in first-out from pages claimed one by one
// from a heap at heap_start. Each request transaction (cmd, req_len) produces
// exactly one response transaction (status, buf_address, freed_len). A request
// is accepted into an item register; once the output register is free, the top
// stack entry is read from cell 0 of the cell row, the response is formed and
// the row shifts one place (push on a good allocate, pop on a good free). The
// start of the next fresh page is kept in a register refreshed every cycle from
// page_count. A response waits in the output register as long as needed; the
// next request is accepted meanwhile and is worked on once that register is free.
// Live entries are tracked only by a count, so there is no clearing pass after
// reset. Registers at paddr 0x0 max_alloc_len, 0x4 heap_start, 0x8 max_pages. The
// user must write them only while the block is idle; the block does not enforce it.
module paged_stack_allocator_top #(
	parameter int PAGE_BYTES   = psa_pkg::PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = psa_pkg::HEADER_BYTES_DEF,
	parameter int STACK_DEPTH  = psa_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_ready,
	input  psa_pkg::in_item_t req_item,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output psa_pkg::out_item_t rsp_item,
	// apb register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import psa_pkg::*;

	// free bytes left in a page stay below PAGE_BYTES
	localparam int FREE_W = $clog2(PAGE_BYTES);
	localparam int EW     = ADDR_W + LEN_W + FREE_W;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	// compare width: holds PAGE_BYTES, need and len + free + header
	localparam int CW     = (((FREE_W + 1) > NEED_W) ? (FREE_W + 1) : NEED_W) + 1;

	// configuration registers
	logic [LEN_W-1:0]   max_alloc_q;
	logic [ADDR_W-1:0]  heap_start_q;
	logic [PAGES_W-1:0] max_pages_q;

	// control state
	logic               busy_q;
	logic               rsp_valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [PAGES_W-1:0] page_count_q;

	// payload registers
	in_item_t          item_q;
	out_item_t         rsp_q;
	logic [ADDR_W-1:0] page_base_q;

	// step logic
	logic              step;
	out_item_t         rsp_next;
	stack_ctl_t        ctl;
	logic [EW-1:0]     top_w;
	logic [EW-1:0]     push_w;
	logic [ADDR_W-1:0] top_addr;
	logic [LEN_W-1:0]  top_len;
	logic [FREE_W-1:0] top_free;
	logic [NEED_W-1:0] need;
	logic [FREE_W-1:0] new_free;
	logic [ADDR_W-1:0] new_addr;
	logic              page_inc;
	logic              page_dec;
	logic              cfg_wr;

	// ---------------------------------------------------------------- apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_alloc_q  <= MAX_ALLOC_RST;
			heap_start_q <= HEAP_START_RST;
			max_pages_q  <= MAX_PAGES_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAX_ALLOC:  max_alloc_q  <= pwdata[LEN_W-1:0];
				REG_HEAP_START: heap_start_q <= pwdata;
				REG_MAX_PAGES:  max_pages_q  <= pwdata[PAGES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_ALLOC:  prdata = 32'(max_alloc_q);
			REG_HEAP_START: prdata = heap_start_q;
			REG_MAX_PAGES:  prdata = 32'(max_pages_q);
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	// one request held at a time; it is worked on once the output register frees
	assign req_ready = !busy_q;
	assign step      = busy_q && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				busy_q <= 1'b1;
			end else if (step) begin
				busy_q <= 1'b0;
			end
			if (step) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req_item;
		end
		if (step) begin
			rsp_q <= rsp_next;
		end
	end

	// start of the next fresh page, refreshed every cycle
	always_ff @(posedge clk) begin
		page_base_q <= heap_start_q + 32'(32'(page_count_q) * 32'(PAGE_BYTES));
	end

	// ---------------------------------------------------------------- step
	assign top_addr = top_w[EW-1 -: ADDR_W];
	assign top_len  = top_w[FREE_W +: LEN_W];
	assign top_free = top_w[FREE_W-1:0];
	assign need     = NEED_W'(item_q.req_len) + NEED_W'(HEADER_BYTES);
	assign push_w   = {new_addr, item_q.req_len, new_free};

	always_comb begin
		rsp_next.status      = ST_OK;
		rsp_next.buf_address = '0;
		rsp_next.freed_len   = '0;
		ctl.push             = 1'b0;
		ctl.pop              = 1'b0;
		new_addr             = '0;
		new_free             = '0;
		page_inc             = 1'b0;
		page_dec             = 1'b0;
		if (item_q.cmd == CMD_ALLOC) begin
			if (item_q.req_len == '0 || item_q.req_len > max_alloc_q ||
			    CW'(need) > CW'(PAGE_BYTES)) begin
				rsp_next.status = ST_BAD_LEN;
			end else if (count_q == CNT_W'(STACK_DEPTH)) begin
				rsp_next.status = ST_FULL;
			end else if (count_q != '0 && CW'(top_free) >= CW'(need)) begin
				// packed right after the top buffer in its page
				new_addr = top_addr + 32'(top_len) + 32'(HEADER_BYTES);
				new_free = FREE_W'(CW'(top_free) - CW'(need));
				ctl.push = 1'b1;
			end else if (page_count_q >= max_pages_q) begin
				rsp_next.status = ST_NO_PAGES;
			end else begin
				// claim a fresh page
				new_addr = page_base_q + 32'(HEADER_BYTES);
				new_free = FREE_W'(CW'(PAGE_BYTES) - CW'(need));
				ctl.push = 1'b1;
				page_inc = 1'b1;
			end
			if (ctl.push) begin
				rsp_next.buf_address = new_addr;
			end
		end else begin
			if (count_q == '0) begin
				rsp_next.status = ST_EMPTY;
			end else begin
				rsp_next.freed_len = top_len;
				ctl.pop            = 1'b1;
				// buffer alone in its page: give the page back
				if (CW'(top_len) + CW'(top_free) + CW'(HEADER_BYTES) == CW'(PAGE_BYTES) &&
				    page_count_q != '0) begin
					page_dec = 1'b1;
				end
			end
		end
		if (!step) begin
			ctl.push = 1'b0;
			ctl.pop  = 1'b0;
			page_inc = 1'b0;
			page_dec = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			page_count_q <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (page_inc) begin
				page_count_q <= page_count_q + 1'b1;
			end else if (page_dec) begin
				page_count_q <= page_count_q - 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- entry row
	psa_stack #(
		.W     (EW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.ctl    (ctl),
		.push_d (push_w),
		.top_q  (top_w)
	);

	// ---------------------------------------------------------------- checks
`ifndef SYNTH
	// live entries never exceed the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("entry count beyond stack depth");

	// a live entry always sits in a claimed page
	a_page_live: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> page_count_q != '0)
		else $error("live entries with no claimed page");

	// count moves only on a step that reports success
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> ((count_q != $past(count_q)) == ($past(rsp_next.status) == ST_OK)))
		else $error("entry count disagrees with status");

	// nothing moves without a step
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(count_q) && $stable(page_count_q)))
		else $error("allocator state changed without a transaction");
`endif

endmodule

// ===== rtl/psa_cell.sv =====
// psa_cell: one stack entry of the allocator's cell row
// depends on psa_pkg for the shift control struct
module psa_cell #(
	parameter int W = 8
) (
	input  logic                clk,
	input  psa_pkg::stack_ctl_t ctl,
	input  logic [W-1:0]        left_d,
	input  logic [W-1:0]        right_d,
	output logic [W-1:0]        q
);
	import psa_pkg::*;

	logic [W-1:0] entry_q;

	// push takes the entry above, pop takes the one below
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= left_d;
		end else if (ctl.pop) begin
			entry_q <= right_d;
		end
	end

	assign q = entry_q;

endmodule

// ===== rtl/psa_stack.sv =====
// psa_stack: row of psa_cell entries forming a shifting lifo, top at cell 0
// depends on psa_pkg and psa_cell
module psa_stack #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  psa_pkg::stack_ctl_t ctl,
	input  logic [W-1:0]        push_d,
	output logic [W-1:0]        top_q
);
	import psa_pkg::*;

	logic [W-1:0] cell_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] left_d;
		logic [W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = push_d;
		end else begin : g_inner_l
			assign left_d = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_q[i];
		end else begin : g_inner_r
			assign right_d = cell_q[i+1];
		end

		psa_cell #(
			.W(W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.left_d  (left_d),
			.right_d (right_d),
			.q       (cell_q[i])
		);
	end

	assign top_q = cell_q[0];

endmodule

// ===== tb/sv/psa_checker.sv =====
`timescale 1ns / 1ps
// psa_checker: predicts the response of every request transaction of the stack allocator
// and compares it field by field; watches the request, response and apb channels, uses psa_pkg
module psa_checker #(
	parameter int PAGE_BYTES   = psa_pkg::PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = psa_pkg::HEADER_BYTES_DEF,
	parameter int STACK_DEPTH  = psa_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  psa_pkg::in_item_t  req_item,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  psa_pkg::out_item_t rsp_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending
);
	import psa_pkg::*;

	// register shadow
	logic [LEN_W-1:0]   cfg_max_len;
	logic [ADDR_W-1:0]  cfg_heap;
	logic [PAGES_W-1:0] cfg_max_pages;

	// shadow of the buffer stack
	logic [ADDR_W-1:0] stk_addr [STACK_DEPTH];
	logic [LEN_W-1:0]  stk_len  [STACK_DEPTH];
	logic [NEED_W-1:0] stk_room [STACK_DEPTH];
	int                live;
	int                pages_used;

	out_item_t outcome_q [$];
	out_item_t want;
	out_item_t got;

	task automatic compute_outcome(input in_item_t rq, output out_item_t rs);
		logic [NEED_W-1:0] need;
		int top;
		rs = '0;
		need = {1'b0, rq.req_len} + NEED_W'(HEADER_BYTES);
		top = live;
		if (rq.cmd == CMD_ALLOC) begin
			if (rq.req_len == '0 || rq.req_len > cfg_max_len || need > NEED_W'(PAGE_BYTES)) begin
				rs.status = ST_BAD_LEN;
			end else if (live >= STACK_DEPTH) begin
				rs.status = ST_FULL;
			end else begin
				if (top > 0 && stk_room[top-1] >= need) begin
					// packs right behind the top buffer in the same page
					rs.buf_address = stk_addr[top-1] + ADDR_W'(stk_len[top-1])
						+ ADDR_W'(HEADER_BYTES);
					stk_room[top] = stk_room[top-1] - need;
				end else if (pages_used >= int'(cfg_max_pages)) begin
					rs.status = ST_NO_PAGES;
				end else begin
					rs.buf_address = cfg_heap + ADDR_W'(pages_used) * ADDR_W'(PAGE_BYTES)
						+ ADDR_W'(HEADER_BYTES);
					stk_room[top] = NEED_W'(PAGE_BYTES) - need;
					pages_used++;
				end
				if (rs.status == ST_OK) begin
					stk_addr[top] = rs.buf_address;
					stk_len[top] = rq.req_len;
					live = top + 1;
				end
			end
		end else begin
			if (live == 0) begin
				rs.status = ST_EMPTY;
			end else begin
				top = live - 1;
				rs.freed_len = stk_len[top];
				// sole buffer of its page: the page goes back
				if (32'(stk_len[top]) + 32'(stk_room[top]) + 32'(HEADER_BYTES)
						== 32'(PAGE_BYTES) && pages_used > 0)
					pages_used--;
				live = top;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_max_len = MAX_ALLOC_RST;
			cfg_heap = HEAP_START_RST;
			cfg_max_pages = MAX_PAGES_RST;
			live = 0;
			pages_used = 0;
			outcome_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MAX_ALLOC:  cfg_max_len = pwdata[LEN_W-1:0];
					REG_HEAP_START: cfg_heap = pwdata[ADDR_W-1:0];
					REG_MAX_PAGES:  cfg_max_pages = pwdata[PAGES_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: response with none expected: status %0d addr %h len %0d",
						$time, rsp_item.status, rsp_item.buf_address, rsp_item.freed_len);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (rsp_item.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, rsp_item.status);
						fail_count++;
					end
					if (rsp_item.buf_address !== want.buf_address) begin
						$display("%0t: buf_address mismatch, expected %h, actual %h",
							$time, want.buf_address, rsp_item.buf_address);
						fail_count++;
					end
					if (rsp_item.freed_len !== want.freed_len) begin
						$display("%0t: freed_len mismatch, expected %0d, actual %0d",
							$time, want.freed_len, rsp_item.freed_len);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				compute_outcome(req_item, got);
				outcome_q.push_back(got);
			end
			pending = outcome_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: stimulus and verdict for paged_stack_allocator_top
// depends on psa_pkg, the rtl and psa_checker, which does all prediction and comparison
module testbench;
	import psa_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	in_item_t    req_item = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	out_item_t   rsp_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;

	// shared pacing knobs: no_gaps turns idling off on both sides for a stretch,
	// rsp_hold asks the response side for one long hold-off
	bit no_gaps = 1'b0;
	int rsp_hold = 0;

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	paged_stack_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	psa_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_item   (req_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_item   (rsp_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// offer one request transaction; returns at the rising edge that accepted it,
	// so valid stays high into the next call and is never dropped and raised in one step
	task automatic send_cmd(input logic cmd, input logic [LEN_W-1:0] len);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_item <= in_item_t'{cmd, len};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// take valid down once the last transaction of a stretch is in
	task automatic go_quiet();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	// wait until every expected response is back, then wait on a little
	// so the two-stage pipe is surely empty before a register write
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly legal lengths up to the limit; noise_pct of them are edge or junk lengths
	function automatic logic [LEN_W-1:0] pick_len(input int lim, input int noise_pct);
		int r;
		logic [LEN_W-1:0] len;
		r = $urandom_range(0, 99);
		if (r < noise_pct) begin
			case ($urandom_range(0, 3))
				0: len = LEN_W'($urandom_range(0, 4095));
				1: len = '0;
				2: len = LEN_W'(lim);
				default: len = LEN_W'(lim + 1);
			endcase
		end else begin
			len = LEN_W'($urandom_range(1, lim));
		end
		return len;
	endfunction

	// random stretch; pause_at makes the sender wait for every response,
	// hold_at asks the receiver for a long hold-off while requests keep coming
	task automatic run_phase(input int n, input int alloc_pct, input int lim,
			input int noise_pct, input int pause_at, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i % 25 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if (i == pause_at) begin
				go_quiet();
				while (pending != 0) @(negedge clk);
			end
			if (i == hold_at)
				rsp_hold = 80;
			if ($urandom_range(0, 99) < alloc_pct)
				send_cmd(CMD_ALLOC, pick_len(lim, noise_pct));
			else
				send_cmd(CMD_FREE, LEN_W'($urandom()));
		end
	endtask

	// response side: random ready gaps per transaction, or one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_hold) @(negedge clk);
				rsp_hold = 0;
			end else if (!no_gaps) begin
				gap = $urandom_range(0, 10);
				if (gap > 0) begin
					rsp_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// main sequence
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: empty free, zero and too long lengths, first fresh page
		send_cmd(CMD_FREE, 12'd0);
		send_cmd(CMD_ALLOC, 12'd0);
		send_cmd(CMD_ALLOC, 12'd513);
		send_cmd(CMD_ALLOC, 12'hFFF);
		send_cmd(CMD_ALLOC, 12'd512);
		send_cmd(CMD_ALLOC, 12'd1);
		send_cmd(CMD_FREE, 12'hFFF);
		send_cmd(CMD_FREE, 12'd0);
		send_cmd(CMD_FREE, 12'd0);
		go_quiet();
		settle();

		// longest length, heap at the top of the address space, a single page
		reg_write(REG_MAX_ALLOC, 32'd4072);
		reg_write(REG_HEAP_START, 32'hFFFF_F000);
		reg_write(REG_MAX_PAGES, 32'd1);
		send_cmd(CMD_ALLOC, 12'd4072);
		send_cmd(CMD_ALLOC, 12'd1);
		send_cmd(CMD_FREE, 12'd0);
		// packing up to an exactly full page, then heap exhausted
		send_cmd(CMD_ALLOC, 12'd2000);
		send_cmd(CMD_ALLOC, 12'd2000);
		send_cmd(CMD_ALLOC, 12'd24);
		send_cmd(CMD_ALLOC, 12'd1);
		send_cmd(CMD_FREE, 12'd0);
		send_cmd(CMD_FREE, 12'd0);
		send_cmd(CMD_FREE, 12'd0);
		go_quiet();
		settle();

		// second page wraps past the top of the address space
		reg_write(REG_MAX_PAGES, 32'd2);
		send_cmd(CMD_ALLOC, 12'd4072);
		send_cmd(CMD_ALLOC, 12'd4072);
		send_cmd(CMD_ALLOC, 12'd4072);
		send_cmd(CMD_FREE, 12'd0);
		send_cmd(CMD_FREE, 12'd0);
		go_quiet();
		settle();

		// reset-like limits, random heap base; sender drains once midway
		reg_write(REG_MAX_ALLOC, 32'd512);
		reg_write(REG_HEAP_START, $urandom() & 32'hFFFF_F000);
		reg_write(REG_MAX_PAGES, 32'd16);
		run_phase(40, 60, 512, 20, 20, -1);
		go_quiet();
		settle();

		// fill the stack to the brim with short buffers, heap at address zero,
		// most pages allowed; long response hold-off backs up the request side
		reg_write(REG_MAX_ALLOC, 32'd64);
		reg_write(REG_HEAP_START, 32'd0);
		reg_write(REG_MAX_PAGES, 32'd4096);
		run_phase(300, 97, 64, 4, -1, 100);
		// mostly frees, popping pages back
		run_phase(40, 10, 64, 10, -1, -1);
		go_quiet();
		settle();

		// smallest limit, single page
		reg_write(REG_MAX_ALLOC, 32'd1);
		reg_write(REG_HEAP_START, $urandom() & 32'hFFFF_F000);
		reg_write(REG_MAX_PAGES, 32'd1);
		run_phase(30, 60, 1, 30, -1, -1);
		go_quiet();
		settle();

		// largest limit, top of the heap, few pages: wraps, bad lengths, no pages
		reg_write(REG_MAX_ALLOC, 32'd4072);
		reg_write(REG_HEAP_START, 32'hFFFF_F000);
		reg_write(REG_MAX_PAGES, 32'd3);
		run_phase(40, 55, 4072, 25, -1, -1);
		go_quiet();
		settle();
		repeat (10) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
